[rtl/lcdx_pkg.sv]
// Shared types, constants and port-update functions for the LCD expander sequencer.
package lcdx_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned StepW = 3;

  localparam logic [ByteW-1:0] CfgAddrReset = 8'h4E;

  // Expander port bits
  localparam logic [ByteW-1:0] BitRs = 8'h01;
  localparam logic [ByteW-1:0] BitRw = 8'h02;
  localparam logic [ByteW-1:0] BitEn = 8'h04;
  localparam logic [ByteW-1:0] BitBl = 8'h08;
  localparam logic [ByteW-1:0] CtlMask = 8'h0F;
  localparam logic [ByteW-1:0] DdramCmd = 8'h80;

  typedef enum logic [2:0] {
    KIND_NIBBLE = 3'd0,
    KIND_CMD    = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_SETPOS = 3'd3,
    KIND_BL_ON  = 3'd4,
    KIND_BL_OFF = 3'd5,
    KIND_RW_LOW = 3'd6,
    KIND_NONE   = 3'd7
  } lcdx_kind_e;

  // Steps of a full byte transfer; a nibble request runs the last three.
  localparam logic [StepW-1:0] StepRs     = 3'd0;
  localparam logic [StepW-1:0] StepHiEnOn = 3'd1;
  localparam logic [StepW-1:0] StepHiNib  = 3'd2;
  localparam logic [StepW-1:0] StepHiEnOf = 3'd3;
  localparam logic [StepW-1:0] StepLoEnOn = 3'd4;
  localparam logic [StepW-1:0] StepLoNib  = 3'd5;
  localparam logic [StepW-1:0] StepLoEnOf = 3'd6;

  typedef struct packed {
    logic             valid;
    lcdx_kind_e       kind;
    logic [StepW-1:0] step;
    logic [ByteW-1:0] data;
  } lcdx_step_t;

  function automatic logic [ByteW-1:0] line_offset(input logic [1:0] row);
    logic [ByteW-1:0] off;
    unique case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h10;
      default: off = 8'h50;
    endcase
    return off;
  endfunction

  function automatic logic single_op(input lcdx_kind_e kind);
    return (kind == KIND_BL_ON) || (kind == KIND_BL_OFF) || (kind == KIND_RW_LOW);
  endfunction

  function automatic logic step_is_last(input lcdx_step_t s);
    return single_op(s.kind) || (s.step == StepLoEnOf);
  endfunction

  function automatic logic [ByteW-1:0] next_shadow(input logic [ByteW-1:0] sh,
                                                    input lcdx_step_t s);
    logic [ByteW-1:0] nx;
    nx = sh;
    unique case (s.kind)
      KIND_BL_ON:  nx = sh | BitBl;
      KIND_BL_OFF: nx = sh & ~BitBl;
      KIND_RW_LOW: nx = sh & ~BitRw;
      default: begin
        unique case (s.step)
          StepRs:     nx = (s.kind == KIND_DATA) ? (sh | BitRs) : (sh & ~BitRs);
          StepHiEnOn,
          StepLoEnOn: nx = sh | BitEn;
          StepHiNib:  nx = (sh & CtlMask) | {s.data[7:4], 4'h0};
          StepLoNib:  nx = (sh & CtlMask) | {s.data[3:0], 4'h0};
          StepHiEnOf,
          StepLoEnOf: nx = sh & ~BitEn;
          default:    nx = sh;
        endcase
      end
    endcase
    return nx;
  endfunction

endpackage

[rtl/lcdx_if.sv]
// Request and result channel interfaces of the LCD expander sequencer.
interface lcdx_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic [5:0] column;
  logic [1:0] row;

  modport source (output valid, kind, value, column, row, input ready);
  modport sink   (input valid, kind, value, column, row, output ready);
endinterface

interface lcdx_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] port_byte;
  logic [7:0] bus_address;
  logic       last;

  modport source (output valid, port_byte, bus_address, last, input ready);
  modport sink   (input valid, port_byte, bus_address, last, output ready);
endinterface

[rtl/lcdx_req_reg.sv]
// Input register: decodes a request and walks its byte steps.
module lcdx_req_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  lcdx_req_if.sink            req_i,
  input  logic                emit_i,
  output lcdx_pkg::lcdx_step_t step_o
);
  import lcdx_pkg::*;

  lcdx_step_t cur_q, cur_d;
  lcdx_kind_e in_kind;
  logic       accept;
  logic       finish;

  assign in_kind     = lcdx_kind_e'(req_i.kind);
  assign finish      = emit_i && step_is_last(cur_q);
  assign req_i.ready = !cur_q.valid || finish;
  assign accept      = req_i.valid && req_i.ready;
  assign step_o      = cur_q;

  always_comb begin
    cur_d = cur_q;
    if (accept) begin
      cur_d.valid = (in_kind != KIND_NONE);
      cur_d.kind  = in_kind;
      cur_d.step  = StepRs;
      cur_d.data  = req_i.value;
      unique case (in_kind)
        KIND_NIBBLE: begin
          cur_d.step = StepLoEnOn;
          cur_d.data = {4'h0, req_i.value[3:0]};
        end
        KIND_SETPOS: begin
          // send as an ordinary command byte
          cur_d.kind = KIND_CMD;
          cur_d.data = (line_offset(req_i.row) + {2'b00, req_i.column}) | DdramCmd;
        end
        default: ;
      endcase
    end else if (finish) begin
      cur_d.valid = 1'b0;
    end else if (emit_i) begin
      cur_d.step = cur_q.step + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q.valid <= 1'b0;
      cur_q.kind  <= KIND_NONE;
      cur_q.step  <= StepRs;
      cur_q.data  <= '0;
    end else begin
      cur_q.valid <= cur_d.valid;
      cur_q.kind  <= cur_d.kind;
      cur_q.step  <= cur_d.step;
      cur_q.data  <= cur_d.data;
    end
  end

endmodule

[rtl/lcdx_port_gen.sv]
// Port shadow and result register: forms one expander byte per step.
module lcdx_port_gen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcdx_pkg::lcdx_step_t step_i,
  input  logic [7:0]           bus_addr_i,
  output logic                 emit_o,
  lcdx_res_if.source           res_o
);
  import lcdx_pkg::*;

  logic [ByteW-1:0] shadow_q, shadow_d;
  logic [ByteW-1:0] byte_q;
  logic [ByteW-1:0] addr_q;
  logic             last_q;
  logic             out_valid_q, out_valid_d;

  assign shadow_d = next_shadow(shadow_q, step_i);
  assign emit_o   = step_i.valid && (!out_valid_q || res_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_o) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (emit_o) begin
        shadow_q <= shadow_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_o) begin
      byte_q <= shadow_d;
      addr_q <= bus_addr_i;
      last_q <= step_is_last(step_i);
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.port_byte   = byte_q;
  assign res_o.bus_address = addr_q;
  assign res_o.last        = last_q;

endmodule

[rtl/char_lcd_nibble_expander_sequencer.sv]
// Top level of the character-LCD 4-bit sequencer over an 8-bit port expander.
//
//   channel   dir  handshake        payload
//   req_i     in   valid/ready      kind, value, column, row
//   res_o     out  valid/ready      port_byte, bus_address, last
//   cfg       in   cfg_we_i         cfg_wdata_i (expander bus address)
//
// A command, data or set-position request emits seven bytes, one per cycle unless the
// result stalls; a half nibble emits three, backlight and rw-low one. The request
// register frees up as its last byte enters the result register, so the next request
// loads in that same cycle. A request of the unused kind is taken and emits nothing.
// Reset clears the port shadow and loads the bus address 0x4E.
// A stalled result holds the result register and the step counter in place.
module char_lcd_nibble_expander_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcdx_req_if.sink   req_i,
  lcdx_res_if.source res_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import lcdx_pkg::*;

  logic [ByteW-1:0] bus_addr_q;
  lcdx_step_t       step;
  logic             emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_addr_q <= CfgAddrReset;
    end else if (cfg_we_i) begin
      bus_addr_q <= cfg_wdata_i;
    end
  end

  lcdx_req_reg u_req_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .emit_i (emit),
    .step_o (step)
  );

  lcdx_port_gen u_port_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .bus_addr_i (bus_addr_q),
    .emit_o     (emit),
    .res_o      (res_o)
  );

endmodule

[rtl/lcdx_checker.sv]
// Port-level assertions for the LCD expander sequencer, bound to the top level.
module lcdx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] res_port_byte_i,
  input logic       res_last_i
);

  // every request ends with enable low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_last_i |-> !res_port_byte_i[2])
    else $error("enable left high on final byte");

  // a stalled mid-request byte means the request is still in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_last_i && !res_ready_i |-> !req_ready_i)
    else $error("new request taken before current one finished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_port_byte_i)
      && $stable(res_last_i))
    else $error("stalled result changed");

  // a reset cycle leaves the result register empty
  assert property (@(posedge clk_i) !rst_ni |=> !res_valid_i)
    else $error("result valid after reset");

endmodule

bind char_lcd_nibble_expander_sequencer lcdx_checker u_lcdx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_ready_i     (req_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_port_byte_i (res_o.port_byte),
  .res_last_i      (res_o.last)
);
